// File: design/gcrm_pkg.sv
package gcrm_pkg;

  localparam int RANGE_BITS       = 17;
  localparam int ANG_W            = 16;
  localparam int COL_W            = 11;
  localparam int ROWW_W           = 12;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_ROW_WIDTH_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [ROWW_W-1:0] ROW_WIDTH_RST   = 12'd1600;
  localparam logic [CFG_W-1:0]  GATE_OFFSET_RST = 16'd80;
  localparam logic [CFG_W-1:0]  GATE_SLOPE_RST  = 16'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_SLOPE  = 2'd2;

  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [31:0] SIN_SEED  = 32'd3864;

  typedef struct packed {
    logic [RANGE_BITS-1:0] r;
    logic                  v;
    logic [ANG_W-1:0]      az;
    logic [ANG_W-1:0]      el;
  } pix_t;

  // one filter job: left, center, right pixel plus output tags
  typedef struct packed {
    pix_t             l;
    pix_t             c;
    pix_t             rt;
    logic [COL_W-1:0] col;
    logic             done;
  } job_t;

  // odd sine polynomial coefficients, Horner order, Q30
  function automatic logic [31:0] sin_coef(input logic [2:0] s);
    logic [31:0] c;
    case (s)
      3'd1:    c = 32'd172272;
      3'd2:    c = 32'd5026997;
      3'd3:    c = 32'd85569306;
      3'd4:    c = 32'd693598668;
      3'd5:    c = 32'd1686629713;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/gcrm_front.sv
module gcrm_front #(
  parameter int MAX_ROW_WIDTH = gcrm_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gcrm_pkg::pix_t              in_pix,
  input  logic [gcrm_pkg::ROWW_W-1:0] row_width,
  output logic                        job_valid,
  input  logic                        job_ready,
  output gcrm_pkg::job_t              job
);
  import gcrm_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROW_WIDTH);

  logic [CNT_W-1:0] k_r;
  pix_t             win0_r, win1_r, head0_r, head1_r;
  job_t             jb_r [3];
  logic [1:0]       jn_r, jh_r;

  logic [12:0] w_ext, w, k_ext, km1;
  logic        accept, last, mid;
  job_t        job_a, job_b, job_c;

  always_comb begin
    w_ext = {1'b0, row_width};
    if (w_ext < 13'd3) begin
      w = 13'd3;
    end else if (w_ext > 13'(MAX_ROW_WIDTH)) begin
      w = 13'(MAX_ROW_WIDTH);
    end else begin
      w = w_ext;
    end
    k_ext = 13'(k_r);
    km1   = k_ext - 13'd1;
    mid   = (k_ext >= 13'd2);
    last  = mid && ((k_ext + 13'd1) >= w);
    job_a = '{l: win0_r, c: win1_r, rt: in_pix, col: km1[COL_W-1:0], done: 1'b0};
    job_b = '{l: win1_r, c: in_pix, rt: head0_r, col: k_ext[COL_W-1:0], done: 1'b0};
    job_c = '{l: in_pix, c: head0_r, rt: head1_r, col: '0, done: 1'b1};
  end

  assign job_valid = (jn_r != 2'd0);
  assign job       = jb_r[jh_r];
  assign in_ready  = (jn_r == 2'd0) || ((jn_r == 2'd1) && job_ready);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      jn_r <= 2'd0;
      jh_r <= 2'd0;
    end else if (accept) begin
      jh_r <= 2'd0;
      jn_r <= last ? 2'd3 : (mid ? 2'd1 : 2'd0);
      k_r  <= last ? '0 : CNT_W'(k_ext + 13'd1);
    end else if (job_valid && job_ready) begin
      jh_r <= jh_r + 2'd1;
      jn_r <= jn_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win0_r <= win1_r;
      win1_r <= in_pix;
      if (k_ext == 13'd0) begin
        head0_r <= in_pix;
      end
      if (k_ext == 13'd1) begin
        head1_r <= in_pix;
      end
      jb_r[0] <= job_a;
      jb_r[1] <= job_b;
      jb_r[2] <= job_c;
    end
  end

endmodule

// File: design/gcrm_queue.sv
module gcrm_queue #(
  parameter int DEPTH = gcrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  gcrm_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output gcrm_pkg::job_t rd_job
);
  import gcrm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

// File: design/gcrm_back.sv
module gcrm_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  output logic                             job_ready,
  input  gcrm_pkg::job_t                   job,
  input  logic [gcrm_pkg::CFG_W-1:0]       gate_offset,
  input  logic [gcrm_pkg::CFG_W-1:0]       gate_slope,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gcrm_pkg::COL_W-1:0]       out_column,
  output logic [gcrm_pkg::RANGE_BITS-1:0]  out_filtered_range,
  output logic                             out_filtered_valid,
  output logic                             out_row_done
);
  import gcrm_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SINIT = 4'd1;
  localparam logic [3:0] ST_SMUL  = 4'd2;
  localparam logic [3:0] ST_SUPD  = 4'd3;
  localparam logic [3:0] ST_QMUL  = 4'd4;
  localparam logic [3:0] ST_QUPD  = 4'd5;
  localparam logic [3:0] ST_HMUL  = 4'd6;
  localparam logic [3:0] ST_HUPD  = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_KMUL  = 4'd9;
  localparam logic [3:0] ST_KUPD  = 4'd10;
  localparam logic [3:0] ST_PMUL  = 4'd11;
  localparam logic [3:0] ST_CMP   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic [3:0]            st_r;
  job_t                  job_r;
  logic [RANGE_BITS-1:0] res_r;
  logic [1:0]            ai_r, qs_r;
  logic [2:0]            s_r;
  logic [30:0]           t_r, t2_r;
  logic [31:0]           p_r;
  logic [30:0]           sm_r [4];
  logic [3:0]            sn_r;
  logic [30:0]           p1_r, p2_r, p3_r, uh_r;
  logic                  p2n_r;
  logic [63:0]           x_r, rt_r, mp_r;
  logic [4:0]            j_r;
  logic [31:0]           ks_r;

  logic                  out_valid_r, out_done_r, out_fv_r;
  logic [COL_W-1:0]      out_col_r;
  logic [RANGE_BITS-1:0] out_rng_r;

  logic [16:0]           ang;
  logic [15:0]           rq;
  logic [30:0]           t_new;
  logic [31:0]           ma, mb;
  logic [RANGE_BITS-1:0] lo, hi, dflt;
  logic                  gated;
  logic [30:0]           mq;
  logic [31:0]           hsum;
  logic [63:0]           bitv, sqs, lhs, rhs;
  logic                  out_free;

  // angle for the current sine: el diff, az diff, then both elevation cosines
  always_comb begin
    case (ai_r)
      2'd0:    ang = {1'b0, job_r.l.el} - {1'b0, job_r.rt.el};
      2'd1:    ang = {1'b0, job_r.l.az} - {1'b0, job_r.rt.az};
      2'd2:    ang = {job_r.l.el, 1'b0} + 17'h08000;
      default: ang = {job_r.rt.el, 1'b0} + 17'h08000;
    endcase
    rq    = ang[15] ? (16'd32768 - {1'b0, ang[14:0]}) : {1'b0, ang[14:0]};
    t_new = {rq, 15'd0};
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      ST_SMUL: begin
        if (s_r == 3'd0) begin
          ma = {1'b0, t_r};
          mb = {1'b0, t_r};
        end else if (s_r == 3'd6) begin
          ma = p_r;
          mb = {1'b0, t_r};
        end else begin
          ma = p_r;
          mb = {1'b0, t2_r};
        end
      end
      ST_QMUL: begin
        case (qs_r)
          2'd0: begin
            ma = {1'b0, sm_r[0]};
            mb = {1'b0, sm_r[0]};
          end
          2'd1: begin
            ma = {1'b0, sm_r[2]};
            mb = {1'b0, sm_r[3]};
          end
          2'd2: begin
            ma = {1'b0, sm_r[1]};
            mb = {1'b0, sm_r[1]};
          end
          default: begin
            ma = {1'b0, p2_r};
            mb = {1'b0, p3_r};
          end
        endcase
      end
      ST_HMUL: begin
        ma = {1'b0, uh_r};
        mb = Q30_ONE - {1'b0, uh_r};
      end
      ST_KMUL: begin
        ma = {16'd0, gate_slope};
        mb = rt_r[31:0];
      end
      ST_PMUL: begin
        ma = ks_r;
        mb = 32'(lo);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    lo   = (job_r.l.r < job_r.rt.r) ? job_r.l.r : job_r.rt.r;
    hi   = (job_r.l.r < job_r.rt.r) ? job_r.rt.r : job_r.l.r;
    gated = job.c.v && job.l.v && job.rt.v;
    if (!job.c.v) begin
      dflt = '0;
    end else if (job.l.v && !job.rt.v) begin
      dflt = (job.l.r > job.c.r) ? job.l.r : job.c.r;
    end else if (job.rt.v && !job.l.v) begin
      dflt = (job.rt.r > job.c.r) ? job.rt.r : job.c.r;
    end else begin
      dflt = job.c.r;
    end
    mq   = mp_r[60:30];
    hsum = {1'b0, p1_r} + {1'b0, mq};
    bitv = 64'd1 << {j_r, 1'b0};
    sqs  = rt_r + bitv;
    lhs  = 64'(hi - lo) << 23;
    rhs  = (64'(gate_offset) << 23) + mp_r;
  end

  assign job_ready = (st_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    mp_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((st_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            st_r <= gated ? ST_SINIT : ST_OUT;
          end
        end
        ST_SINIT: st_r <= ST_SMUL;
        ST_SMUL:  st_r <= ST_SUPD;
        ST_SUPD: begin
          if (s_r != 3'd6) begin
            st_r <= ST_SMUL;
          end else if (ai_r == 2'd3) begin
            st_r <= ST_QMUL;
          end else begin
            st_r <= ST_SINIT;
          end
        end
        ST_QMUL: st_r <= ST_QUPD;
        ST_QUPD: st_r <= (qs_r == 2'd3) ? ST_HMUL : ST_QMUL;
        ST_HMUL: st_r <= ST_HUPD;
        ST_HUPD: st_r <= ST_SQRT;
        ST_SQRT: begin
          if (j_r == 5'd0) begin
            st_r <= ST_KMUL;
          end
        end
        ST_KMUL: st_r <= ST_KUPD;
        ST_KUPD: st_r <= ST_PMUL;
        ST_PMUL: st_r <= ST_CMP;
        ST_CMP:  st_r <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_r <= job;
          res_r <= dflt;
          ai_r  <= 2'd0;
          qs_r  <= 2'd0;
        end
      end
      ST_SINIT: begin
        t_r        <= t_new;
        sn_r[ai_r] <= ang[16];
        p_r        <= SIN_SEED;
        s_r        <= 3'd0;
      end
      ST_SUPD: begin
        if (s_r == 3'd0) begin
          t2_r <= mq;
        end else if (s_r == 3'd6) begin
          sm_r[ai_r] <= mq;
          ai_r       <= ai_r + 2'd1;
        end else begin
          p_r <= sin_coef(s_r) - mp_r[61:30];
        end
        s_r <= s_r + 3'd1;
      end
      ST_QUPD: begin
        case (qs_r)
          2'd0: p1_r <= mq;
          2'd1: begin
            p2_r  <= mq;
            p2n_r <= sn_r[2] ^ sn_r[3];
          end
          2'd2: p3_r <= mq;
          default: begin
            // h = sdp^2 +/- cos*cos*sdt^2, clamped to [0, 1]
            if (p2n_r) begin
              uh_r <= (mq > p1_r) ? '0 : (p1_r - mq);
            end else begin
              uh_r <= (hsum > Q30_ONE) ? Q30_ONE[30:0] : hsum[30:0];
            end
          end
        endcase
        qs_r <= qs_r + 2'd1;
      end
      ST_HUPD: begin
        x_r  <= {3'd0, mp_r[58:28], 30'd0};
        rt_r <= '0;
        j_r  <= 5'd31;
      end
      ST_SQRT: begin
        if (x_r >= sqs) begin
          x_r  <= x_r - sqs;
          rt_r <= (rt_r >> 1) + bitv;
        end else begin
          rt_r <= rt_r >> 1;
        end
        j_r <= j_r - 5'd1;
      end
      ST_KUPD: ks_r <= mp_r[46:15];
      ST_CMP: begin
        if (lhs <= rhs) begin
          if (job_r.c.r < lo) begin
            res_r <= lo;
          end else if (job_r.c.r > hi) begin
            res_r <= hi;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_col_r  <= job_r.col;
          out_rng_r  <= res_r;
          out_fv_r   <= job_r.c.v;
          out_done_r <= job_r.done;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_column         = out_col_r;
  assign out_filtered_range = out_rng_r;
  assign out_filtered_valid = out_fv_r;
  assign out_row_done       = out_done_r;

  a_sqrt_arg: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SQRT) |-> ({1'b0, uh_r} <= Q30_ONE))
    else $error("gate h out of [0,1] during square root");

  a_sin_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SMUL || st_r == ST_SUPD) |-> (s_r <= 3'd6))
    else $error("sine step counter overrun");

  a_cmp_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CMP) |=> (st_r == ST_OUT))
    else $error("gate compare not followed by result load");

  a_lo_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CMP) |-> (lo <= hi))
    else $error("neighbor min/max swapped");

endmodule

// File: design/gated_circular_row_median3.sv
// Channel | Ports                                               | Transfer when
// --------+-----------------------------------------------------+------------------------
// in      | in_range_mm, in_range_valid, in_azimuth, in_elevation| in_valid & in_ready
// out     | out_column, out_filtered_range, out_filtered_valid,  | out_valid & out_ready
//         | out_row_done                                         |
// cfg     | cfg_we, cfg_index, cfg_wdata                         | cfg_we (no wait)
//
// Cycles: front takes one pixel every cycle while it has no job left, or its last is
//   taken; a row-closing pixel makes three jobs, handed over one per cycle if taken.
// Back end: an ungated job goes straight to the output state; a gated job runs four
//   sines (7 shared multiplies each), 7 more multiplies and a 32-step square root.
// Sustained rate is set by the single shared 32x32 multiplier and the sqrt loop.
// Reset (rst_n low, synchronous) clears column count, job queue and sequencers;
//   config returns to row_width 1600, gate_offset 80, gate_slope 1.0.
// Stalls: the job queue lets the front keep taking pixels while the back works;
//   the output register holds one result while the back finishes the next.
module gated_circular_row_median3 #(
  parameter int MAX_ROW_WIDTH = gcrm_pkg::MAX_ROW_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = gcrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gcrm_pkg::RANGE_BITS-1:0]   in_range_mm,
  input  logic                              in_range_valid,
  input  logic signed [gcrm_pkg::ANG_W-1:0] in_azimuth,
  input  logic signed [gcrm_pkg::ANG_W-1:0] in_elevation,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcrm_pkg::COL_W-1:0]        out_column,
  output logic [gcrm_pkg::RANGE_BITS-1:0]   out_filtered_range,
  output logic                              out_filtered_valid,
  output logic                              out_row_done,
  input  logic                              cfg_we,
  input  logic [gcrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcrm_pkg::CFG_W-1:0]        cfg_wdata
);
  import gcrm_pkg::*;

  logic [ROWW_W-1:0] row_width_r;
  logic [CFG_W-1:0]  gate_offset_r, gate_slope_r;

  pix_t in_pix;
  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  // config registers; unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RST;
      gate_offset_r <= GATE_OFFSET_RST;
      gate_slope_r  <= GATE_SLOPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:   row_width_r   <= cfg_wdata[ROWW_W-1:0];
        REG_GATE_OFFSET: gate_offset_r <= cfg_wdata;
        REG_GATE_SLOPE:  gate_slope_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_pix = '{r: in_range_mm, v: in_range_valid,
                    az: $unsigned(in_azimuth), el: $unsigned(in_elevation)};

  // front: column count, sliding window, row head, job build
  gcrm_front #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (in_pix),
    .row_width (row_width_r),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  gcrm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_job   (f_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_job   (q_job)
  );

  // back: median / gate evaluation with shared multiplier
  gcrm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (q_valid),
    .job_ready          (q_ready),
    .job                (q_job),
    .gate_offset        (gate_offset_r),
    .gate_slope         (gate_slope_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_column         (out_column),
    .out_filtered_range (out_filtered_range),
    .out_filtered_valid (out_filtered_valid),
    .out_row_done       (out_row_done)
  );

endmodule

// File: tb/median_checker.sv
`timescale 1ns / 1ps

module median_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [gcrm_pkg::RANGE_BITS-1:0]   in_range_mm,
  input  logic                              in_range_valid,
  input  logic signed [gcrm_pkg::ANG_W-1:0] in_azimuth,
  input  logic signed [gcrm_pkg::ANG_W-1:0] in_elevation,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [gcrm_pkg::COL_W-1:0]        out_column,
  input  logic [gcrm_pkg::RANGE_BITS-1:0]   out_filtered_range,
  input  logic                              out_filtered_valid,
  input  logic                              out_row_done,
  input  logic                              cfg_we,
  input  logic [gcrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcrm_pkg::CFG_W-1:0]        cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import gcrm_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [COL_W-1:0]      col;
    logic [RANGE_BITS-1:0] rng;
    logic                  fv;
    logic                  done;
  } filt_px_t;

  logic [ROWW_W-1:0] row_w;
  logic [CFG_W-1:0]  g_offset;
  logic [CFG_W-1:0]  g_slope;
  int                col_cnt;
  pix_t              win [2];
  pix_t              head [2];
  filt_px_t          filt_q [$];

  // sine, 131072 units per circle, Q30, truncating odd polynomial
  function automatic longint sin_q30(input logic [31:0] ang);
    logic [1:0]       q;
    longint unsigned  r, t, t2, p;
    q = ang[16:15];
    r = ang[14:0];
    if (q[0]) r = 64'd32768 - r;
    t  = r << 15;
    t2 = (t * t) >> 30;
    p  = 64'd172272 - ((64'd3864 * t2) >> 30);
    p  = 64'd5026997 - ((p * t2) >> 30);
    p  = 64'd85569306 - ((p * t2) >> 30);
    p  = 64'd693598668 - ((p * t2) >> 30);
    p  = 64'd1686629713 - ((p * t2) >> 30);
    p  = (p * t) >> 30;
    return q[1] ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    longint unsigned ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p  = (ua * ub) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // sin of angle between two pixel directions, Q30
  function automatic longint unsigned sin_apart(input pix_t a, input pix_t b);
    longint          sdp, sdt, ca, cb, h;
    longint unsigned uh, s2;
    sdp = sin_q30({16'd0, a.el} - {16'd0, b.el});
    sdt = sin_q30({16'd0, a.az} - {16'd0, b.az});
    ca  = sin_q30({16'd0, a.el} * 32'd2 + 32'd32768);
    cb  = sin_q30({16'd0, b.el} * 32'd2 + 32'd32768);
    h   = mul_q30(sdp, sdp) + mul_q30(mul_q30(ca, cb), mul_q30(sdt, sdt));
    if (h < 0) h = 0;
    if (h > longint'(ONE_Q30)) h = ONE_Q30;
    uh = h;
    s2 = (64'd4 * (uh * (ONE_Q30 - uh))) >> 30;
    return int_sqrt(s2 << 30);
  endfunction

  function automatic filt_px_t median_px(input pix_t l, input pix_t c, input pix_t r,
                                         input int col, input logic done);
    filt_px_t        o;
    longint unsigned res, lo, hi, ks, lhs, rhs;
    res = 0;
    if (c.v) begin
      res = c.r;
      if (l.v && r.v) begin
        lo  = (l.r < r.r) ? l.r : r.r;
        hi  = (l.r < r.r) ? r.r : l.r;
        ks  = (longint'(g_slope) * sin_apart(l, r)) >> 15;
        lhs = (hi - lo) << 23;
        rhs = (longint'(g_offset) << 23) + ks * lo;
        // discontinuity gate: only smooth when neighbors agree
        if (lhs <= rhs) begin
          if (c.r < lo) res = lo;
          else if (c.r > hi) res = hi;
        end
      end else if (l.v) begin
        res = (l.r > c.r) ? l.r : c.r;
      end else if (r.v) begin
        res = (r.r > c.r) ? r.r : c.r;
      end
    end
    o.col  = COL_W'(col);
    o.rng  = RANGE_BITS'(res);
    o.fv   = c.v;
    o.done = done;
    return o;
  endfunction

  task automatic add_expected(input filt_px_t p);
    filt_q = {filt_q, p};
  endtask

  task automatic take_pixel(input pix_t cur);
    int k, w;
    w = row_w;
    if (w < 3) w = 3;
    if (w > MAX_ROW_WIDTH_DEF) w = MAX_ROW_WIDTH_DEF;
    k = col_cnt;
    if (k == 0) head[0] = cur;
    else if (k == 1) head[1] = cur;
    else add_expected(median_px(win[0], win[1], cur, k - 1, 1'b0));
    if (k >= 2 && k + 1 >= w) begin
      add_expected(median_px(win[1], cur, head[0], k, 1'b0));
      add_expected(median_px(cur, head[0], head[1], 0, 1'b1));
      col_cnt = 0;
    end else begin
      col_cnt = k + 1;
    end
    win[0] = win[1];
    win[1] = cur;
  endtask

  always @(posedge clk) begin
    filt_px_t exp_px;
    pix_t     cur;
    if (!rst_n) begin
      row_w    = ROW_WIDTH_RST;
      g_offset = GATE_OFFSET_RST;
      g_slope  = GATE_SLOPE_RST;
      col_cnt  = 0;
      win[0]   = '0;
      win[1]   = '0;
      head[0]  = '0;
      head[1]  = '0;
      filt_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_WIDTH:   row_w    = cfg_wdata[ROWW_W-1:0];
          REG_GATE_OFFSET: g_offset = cfg_wdata;
          REG_GATE_SLOPE:  g_slope  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        cur.r  = in_range_mm;
        cur.v  = in_range_valid;
        cur.az = in_azimuth;
        cur.el = in_elevation;
        take_pixel(cur);
      end
      if (out_valid && out_ready) begin
        if (filt_q.size() == 0) begin
          $display("%0t: unexpected result col %0d range %0d", $time, out_column,
                   out_filtered_range);
          fail_count++;
        end else begin
          exp_px = filt_q.pop_front();
          if (out_column !== exp_px.col) begin
            $display("%0t: column exp %0d got %0d", $time, exp_px.col, out_column);
            fail_count++;
          end
          if (out_filtered_range !== exp_px.rng) begin
            $display("%0t: range col %0d exp %0d got %0d", $time, exp_px.col,
                     exp_px.rng, out_filtered_range);
            fail_count++;
          end
          if (out_filtered_valid !== exp_px.fv) begin
            $display("%0t: valid col %0d exp %0b got %0b", $time, exp_px.col,
                     exp_px.fv, out_filtered_valid);
            fail_count++;
          end
          if (out_row_done !== exp_px.done) begin
            $display("%0t: row_done col %0d exp %0b got %0b", $time, exp_px.col,
                     exp_px.done, out_row_done);
            fail_count++;
          end
        end
      end
    end
    pending = filt_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gcrm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN       = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [RANGE_BITS-1:0]      in_range_mm;
  logic                       in_range_valid;
  logic signed [ANG_W-1:0]    in_azimuth;
  logic signed [ANG_W-1:0]    in_elevation;
  logic                       out_valid;
  logic                       out_ready;
  logic [COL_W-1:0]           out_column;
  logic [RANGE_BITS-1:0]      out_filtered_range;
  logic                       out_filtered_valid;
  logic                       out_row_done;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  int fail_count;
  int pending;
  int burst_left;
  int cycles;
  int sink_phase;
  int sink_mode;

  // scan-like state for random pixels
  logic [RANGE_BITS-1:0] base_rng;
  logic [ANG_W-1:0]      scan_az;
  logic [ANG_W-1:0]      scan_el;

  gated_circular_row_median3 u_dut (.*);

  median_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: stall style picked at random from four modes
  initial begin
    sink_phase = 0;
    sink_mode  = 0;
  end
  always @(negedge clk) begin
    if (sink_phase == 0) begin
      sink_mode  = $urandom_range(0, 3);
      sink_phase = 64;
    end
    sink_phase--;
    case (sink_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // one pixel transfer; sender runs in bursts with random gaps between them
  task automatic send_px(input logic [RANGE_BITS-1:0] r, input logic v,
                         input logic [ANG_W-1:0] az, input logic [ANG_W-1:0] el);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_range_mm    <= r;
    in_range_valid <= v;
    in_azimuth     <= az;
    in_elevation   <= el;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // block idle: every result back, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly a smooth scan with small jumps; sometimes full-range noise
  task automatic send_random_px(input int valid_pct);
    logic [RANGE_BITS-1:0] r;
    logic                  v;
    int                    sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      base_rng = RANGE_BITS'($urandom_range(0, 131071));
      scan_az  = ANG_W'($urandom);
      scan_el  = ANG_W'($urandom);
    end
    if (sel < 20) r = RANGE_BITS'($urandom_range(0, 131071));
    else if (sel < 30) r = base_rng + RANGE_BITS'($urandom_range(0, 4000));
    else r = base_rng + RANGE_BITS'($urandom_range(0, 120));
    v = ($urandom_range(0, 99) < valid_pct);
    scan_az = scan_az + ANG_W'($urandom_range(0, 300));
    if ($urandom_range(0, 9) == 0) scan_el = scan_el + ANG_W'($urandom_range(0, 2000));
    send_px(r, v, scan_az, scan_el);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] ofs,
                              input logic [CFG_W-1:0] slope, input int count,
                              input int valid_pct);
    wait_idle();
    write_reg(REG_ROW_WIDTH, width);
    write_reg(REG_GATE_OFFSET, ofs);
    write_reg(REG_GATE_SLOPE, slope);
    repeat (count) send_random_px(valid_pct);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_range_mm    = '0;
    in_range_valid = 1'b0;
    in_azimuth     = '0;
    in_elevation   = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    burst_left     = 0;
    base_rng       = 17'd5000;
    scan_az        = '0;
    scan_el        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config, mid-row: range and angle extremes, valid combos except right-only
    send_px(17'd0,      1'b1, 16'h8000, 16'h7FFF);
    send_px(17'd131071, 1'b1, 16'h7FFF, 16'h8000);
    send_px(17'd1000,   1'b1, 16'h0000, 16'h0000);
    send_px(17'd1050,   1'b1, 16'h0010, 16'h0000);
    send_px(17'd900,    1'b1, 16'h0020, 16'h0000);
    send_px(17'd131071, 1'b0, 16'hFFFF, 16'hFFFF);
    send_px(17'd2000,   1'b1, 16'h0030, 16'h0000);
    send_px(17'd1500,   1'b0, 16'h0040, 16'h0000);
    send_px(17'd2500,   1'b1, 16'h0050, 16'h0000);
    wait_idle();
    // shrink the row while column 9 is next: that pixel closes the row
    write_reg(REG_ROW_WIDTH, 16'd4);
    send_px(17'd1200, 1'b1, 16'h0060, 16'h0000);
    // width below three clamps to three; exactly two valid takes the larger
    wait_idle();
    write_reg(REG_ROW_WIDTH, 16'd0);
    write_reg(2'd3, 16'hFFFF);             // unmapped index, ignored
    send_px(17'd300, 1'b1, 16'h0000, 16'h0000);
    send_px(17'd700, 1'b1, 16'h0100, 16'h0000);
    send_px(17'd500, 1'b0, 16'h0200, 16'h0000);
    send_px(17'd300, 1'b0, 16'h0000, 16'h0000);
    send_px(17'd700, 1'b1, 16'h0100, 16'h0000);
    send_px(17'd500, 1'b0, 16'h0200, 16'h0000);
    // gate fully closed vs. wide open on a big jump
    wait_idle();
    write_reg(REG_GATE_OFFSET, 16'd0);
    write_reg(REG_GATE_SLOPE, 16'd0);
    write_reg(REG_ROW_WIDTH, 16'd3);
    send_px(17'd1000, 1'b1, 16'h0000, 16'h0000);
    send_px(17'd9000, 1'b1, 16'h0100, 16'h0000);
    send_px(17'd1002, 1'b1, 16'h0200, 16'h0000);
    wait_idle();
    write_reg(REG_GATE_OFFSET, 16'hFFFF);
    write_reg(REG_GATE_SLOPE, 16'hFFFF);
    send_px(17'd1000,   1'b1, 16'h0000, 16'h8000);
    send_px(17'd131071, 1'b1, 16'h4000, 16'h7FFF);
    send_px(17'd0,      1'b1, 16'h8000, 16'h0000);

    // random part, ~165 pixels over several settings
    random_phase(16'd5,    16'd80,    16'd256,   30, 80);
    random_phase(16'd3,    16'd0,     16'd0,     24, 85);
    random_phase(16'd7,    16'd200,   16'd1024,  30, 90);
    random_phase(16'd12,   16'hFFFF,  16'hFFFF,  25, 75);
    random_phase(16'd4,    16'd30,    16'd64,    20, 60);
    random_phase(16'd9,    16'd1000,  16'd4096,  26, 95);
    // 4095 clamps to the widest row; a short stretch of its first columns
    random_phase(16'd4095, 16'd80,    16'd256,   10, 70);

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/gcrm_pkg.sv
design/gcrm_front.sv
design/gcrm_queue.sv
design/gcrm_back.sv
design/gated_circular_row_median3.sv
tb/median_checker.sv
tb/testbench.sv
